/* rtl/lec_pkg.sv */
package lec_pkg;

  localparam logic [7:0] NEWLINE_CHAR    = 8'd10;
  localparam logic [7:0] ESC_CHAR        = 8'h51;
  localparam logic [7:0] DIGIT_BASE      = 8'h61;
  localparam logic [7:0] DIGIT_LAST      = 8'h70;
  localparam logic [7:0] MIN_ENC_WIDTH   = 8'd3;
  localparam logic [7:0] LINE_WIDTH_RST  = 8'd80;
  localparam logic       DECODING_RST    = 1'b0;
  localparam int         MAX_RESULTS     = 4;

  typedef enum logic {
    CFG_DECODING   = 1'b0,
    CFG_LINE_WIDTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic       decoding;
    logic [7:0] line_width;
  } lec_cfg_t;

  // All results caused by one item, produced in a single pass.
  typedef struct packed {
    logic [2:0]                   count;
    logic                         error;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } lec_res_t;

endpackage

/* rtl/lec_core.sv */
module lec_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  input  lec_pkg::lec_cfg_t cfg,
  output lec_pkg::lec_res_t res
);
  import lec_pkg::*;

  typedef struct packed {
    logic [7:0] column_count;
    logic       any_output;
    logic [1:0] escape_phase;
    logic [3:0] high_nibble;
    logic       error_seen;
  } lec_state_t;

  lec_state_t      state_r;
  lec_state_t      state_nxt;
  logic [2:0][7:0] chars;
  logic [1:0]      nchars;
  logic [7:0]      width;
  logic [7:0]      col;
  logic [2:0]      n;
  logic [7:0]      digit;
  logic            err;
  logic            is_letter;
  logic            is_digit;

  assign is_letter = (data_byte >= 8'h41 && data_byte <= 8'h5A) ||
                     (data_byte >= 8'h61 && data_byte <= 8'h7A);
  assign is_digit  = (data_byte >= DIGIT_BASE) && (data_byte <= DIGIT_LAST);
  assign digit     = data_byte - DIGIT_BASE;

  always_comb begin
    state_nxt = state_r;
    res       = '0;
    chars     = '0;
    nchars    = 2'd0;
    err       = 1'b0;
    width     = cfg.line_width;
    col       = 8'd0;
    n         = 3'd0;

    if (state_r.error_seen) begin
      err = 1'b1;
    end else if (end_of_stream) begin
      if (cfg.decoding &&
          (state_r.escape_phase == 2'd1 || state_r.escape_phase == 2'd2)) begin
        err = 1'b1;
      end else begin
        if (state_r.any_output) begin
          res.count    = 3'd1;
          res.bytes[0] = NEWLINE_CHAR;
        end
        state_nxt.column_count = 8'd0;
        state_nxt.any_output   = 1'b0;
        state_nxt.escape_phase = 2'd0;
        state_nxt.high_nibble  = 4'd0;
      end
    end else if (data_byte[7]) begin
      err = 1'b1;
    end else if (!cfg.decoding) begin
      if (width < MIN_ENC_WIDTH) begin
        width = MIN_ENC_WIDTH;
      end
      if (data_byte == ESC_CHAR) begin
        chars[0] = ESC_CHAR;
        chars[1] = ESC_CHAR;
        nchars   = 2'd2;
      end else if (is_letter) begin
        chars[0] = data_byte;
        nchars   = 2'd1;
      end else begin
        chars[0] = ESC_CHAR;
        chars[1] = DIGIT_BASE + {4'd0, data_byte[7:4]};
        chars[2] = DIGIT_BASE + {4'd0, data_byte[3:0]};
        nchars   = 2'd3;
      end
    end else if (is_letter) begin
      if (state_r.escape_phase == 2'd1) begin
        if (data_byte == ESC_CHAR) begin
          state_nxt.escape_phase = 2'd0;
          chars[0] = ESC_CHAR;
          nchars   = 2'd1;
        end else if (is_digit) begin
          state_nxt.high_nibble  = digit[3:0];
          state_nxt.escape_phase = 2'd2;
        end else begin
          err = 1'b1;
        end
      end else if (state_r.escape_phase == 2'd2) begin
        if (!is_digit) begin
          err = 1'b1;
        end else begin
          state_nxt.escape_phase = 2'd0;
          state_nxt.high_nibble  = 4'd0;
          chars[0] = {state_r.high_nibble, digit[3:0]};
          nchars   = 2'd1;
        end
      end else if (data_byte == ESC_CHAR) begin
        state_nxt.escape_phase = 2'd1;
      end else begin
        state_nxt.escape_phase = 2'd0;
        chars[0] = data_byte;
        nchars   = 2'd1;
      end
    end

    // Lay the characters out, breaking the line where the column is full.
    col = state_r.column_count;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(nchars)) begin
        if (width != 8'd0 && col >= width) begin
          res.bytes[n[1:0]] = NEWLINE_CHAR;
          n   = n + 3'd1;
          col = 8'd0;
        end
        res.bytes[n[1:0]] = chars[i];
        n = n + 3'd1;
        if (col != 8'hFF) begin
          col = col + 8'd1;
        end
      end
    end
    if (nchars != 2'd0) begin
      res.count              = n;
      state_nxt.column_count = col;
      state_nxt.any_output   = 1'b1;
    end

    if (err) begin
      res                  = '0;
      res.count            = 3'd1;
      res.error            = 1'b1;
      state_nxt            = state_r;
      state_nxt.error_seen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/lec_emit.sv */
module lec_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lec_pkg::lec_res_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_is_last,
  output logic              out_error_flag
);
  import lec_pkg::*;

  logic [MAX_RESULTS-1:0][7:0] entries_r;
  logic [2:0]                  cnt_r;
  logic [1:0]                  idx_r;
  logic                        err_r;

  assign out_valid      = (cnt_r != 3'd0);
  assign out_byte       = entries_r[idx_r];
  assign out_is_last    = (cnt_r == 3'd1);
  assign out_error_flag = err_r;
  // The buffer can take the next item as its last result leaves.
  assign free           = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= res.count;
      idx_r <= 2'd0;
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries_r <= res.bytes;
      err_r     <= res.error;
    end
  end

endmodule

/* rtl/letter_escape_codec_top.sv */
// Channel  Handshake           Payload
// in       in_valid/in_ready   in_data_byte[7:0], in_end_of_stream
// out      out_valid/out_ready out_byte[7:0], out_is_last, out_error_flag
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data[7:0]
//
// An item is registered in the input register and is expanded in one pass into the
// result buffer, which then sends one result per cycle while out_ready is high; an item
// causes from zero to four results.
// Reset (synchronous, rst_n low) empties both registers, clears the stream state and
// loads the default configuration. A stalled output holds the buffer, which in turn holds
// the input register; the input register takes one further item while the buffer sends.
module letter_escape_codec_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_last,
  output logic       out_error_flag,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import lec_pkg::*;

  lec_cfg_t   cfg_r;
  logic       hold_valid_r;
  logic [7:0] hold_byte_r;
  logic       hold_eos_r;
  logic       buf_free;
  logic       load;
  lec_res_t   res;

  assign cfg_ready = 1'b1;
  assign load      = hold_valid_r && buf_free;
  assign in_ready  = !hold_valid_r || buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decoding   <= DECODING_RST;
      cfg_r.line_width <= LINE_WIDTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DECODING:   cfg_r.decoding   <= cfg_data[0];
        CFG_LINE_WIDTH: cfg_r.line_width <= cfg_data;
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte_r <= in_data_byte;
      hold_eos_r  <= in_end_of_stream;
    end
  end

  lec_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (load),
    .data_byte     (hold_byte_r),
    .end_of_stream (hold_eos_r),
    .cfg           (cfg_r),
    .res           (res)
  );

  lec_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .res            (res),
    .free           (buf_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_is_last    (out_is_last),
    .out_error_flag (out_error_flag)
  );

endmodule
